### rtl/cfifo_pkg.sv
package cfifo_pkg;

    // Ring geometry
    localparam int MAX_DEPTH = 64;
    localparam int IDX_W     = $clog2(MAX_DEPTH);
    localparam int SIZE_W    = 7;
    localparam int BYTE_W    = 8;
    localparam int CMD_W     = 3;
    localparam int ERR_W     = 3;

    // Stream word layout
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Ring size after reset
    localparam logic [SIZE_W-1:0] RING_SIZE_RST = SIZE_W'(MAX_DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 3'd0,
        CMD_PEEK    = 3'd1,
        CMD_REMOVE  = 3'd2,
        CMD_DEQUEUE = 3'd3,
        CMD_CLEAR   = 3'd4
    } t_cmd;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK            = 3'd0,
        ERR_ENQUEUE_FULL  = 3'd1,
        ERR_PEEK_EMPTY    = 3'd2,
        ERR_REMOVE_EMPTY  = 3'd3,
        ERR_DEQUEUE_EMPTY = 3'd4
    } t_err;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the incoming word
        logic commit;   // execute the command and load the result register
    } t_dp_ctrl;

endpackage

### rtl/cfifo_ctrl.sv
module cfifo_ctrl
    import cfifo_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    input  logic     i_m_tready,
    output logic     o_s_tready,
    output logic     o_m_tvalid,
    output t_dp_ctrl o_ctrl
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        o_s_tready     = 1'b0;
        o_ctrl.capture = 1'b0;
        o_ctrl.commit  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // Take no word while reset is held
                o_s_tready     = i_rst_n;
                o_ctrl.capture = i_s_tvalid && i_rst_n;
                if (i_s_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // Execute only once the result register is free or draining
                if (!r_out_valid || i_m_tready) begin
                    o_ctrl.commit = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold the result word until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        if (o_ctrl.commit) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

### rtl/cfifo_dp.sv
module cfifo_dp
    import cfifo_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_ctrl             i_ctrl,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_cfg_we,
    input  logic [SIZE_W-1:0]    i_cfg_wdata,
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    logic [BYTE_W-1:0] mem [MAX_DEPTH];

    logic [SIZE_W-1:0] r_ring_size;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic [CMD_W-1:0]  r_cmd;
    logic [BYTE_W-1:0] r_din;
    logic [BYTE_W-1:0] r_rd_data;

    logic [BYTE_W-1:0] r_out_data, n_out_data;
    logic              r_out_empty, n_out_empty;
    logic              r_out_full, n_out_full;
    t_err              r_out_err, n_out_err;

    logic [SIZE_W-1:0] size_used;
    logic              wr_en;
    logic              cur_empty;
    logic              cur_full;

    // Step an index by one and wrap at the ring size in use
    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                  input logic [SIZE_W-1:0] sz);
        logic [SIZE_W-1:0] nxt;
        nxt = SIZE_W'(idx) + SIZE_W'(1);
        return (nxt >= sz) ? '0 : nxt[IDX_W-1:0];
    endfunction

    // Clamp the ring size register into 1..MAX_DEPTH
    always_comb begin
        if (r_ring_size == '0) begin
            size_used = SIZE_W'(1);
        end else if (r_ring_size > SIZE_W'(MAX_DEPTH)) begin
            size_used = SIZE_W'(MAX_DEPTH);
        end else begin
            size_used = r_ring_size;
        end
    end

    assign cur_empty = (r_head == r_tail);
    assign cur_full  = (advance(r_tail, size_used) == r_head);

    // Execute the latched command
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_out_data = '0;
        n_out_err  = ERR_OK;
        wr_en      = 1'b0;
        case (t_cmd'(r_cmd))
            CMD_ENQUEUE: begin
                if (cur_full) begin
                    n_out_err = ERR_ENQUEUE_FULL;
                end else begin
                    wr_en  = 1'b1;
                    n_tail = advance(r_tail, size_used);
                end
            end
            CMD_PEEK: begin
                if (cur_empty) begin
                    n_out_err = ERR_PEEK_EMPTY;
                end else begin
                    n_out_data = r_rd_data;
                end
            end
            CMD_REMOVE: begin
                if (cur_empty) begin
                    n_out_err = ERR_REMOVE_EMPTY;
                end else begin
                    n_head = advance(r_head, size_used);
                end
            end
            CMD_DEQUEUE: begin
                if (cur_empty) begin
                    n_out_err = ERR_DEQUEUE_EMPTY;
                end else begin
                    n_out_data = r_rd_data;
                    n_head     = advance(r_head, size_used);
                end
            end
            CMD_CLEAR: begin
                n_head = '0;
                n_tail = '0;
            end
            default: begin
            end
        endcase
        n_out_empty = (n_head == n_tail);
        n_out_full  = (advance(n_tail, size_used) == n_head);
    end

    // Config register and ring indices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= RING_SIZE_RST;
            r_head      <= '0;
            r_tail      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_ring_size <= i_cfg_wdata;
            end
            if (i_ctrl.commit) begin
                r_head <= n_head;
                r_tail <= n_tail;
            end
        end
    end

    // Latch the incoming word
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd <= i_s_tdata[CMD_W-1:0];
            r_din <= i_s_tdata[CMD_W +: BYTE_W];
        end
    end

    // Ring store: write at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (i_ctrl.commit && wr_en) begin
            mem[r_tail] <= r_din;
        end
        r_rd_data <= mem[r_head];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.commit) begin
            r_out_data  <= n_out_data;
            r_out_empty <= n_out_empty;
            r_out_full  <= n_out_full;
            r_out_err   <= n_out_err;
        end
    end

    assign o_m_tdata = {(M_TDATA_W - BYTE_W - 2 - ERR_W)'(0),
                        r_out_err, r_out_full, r_out_empty, r_out_data};

endmodule

### rtl/circular_char_fifo.sv
// Byte FIFO in a 64-entry ring store. Each input word carries one command
// (enqueue, peek, remove, dequeue, clear) and yields exactly one result word
// with the peeked or dequeued byte, the empty and full flags after the
// command and an error code. The ring size register (1..64, reset 64; 0 acts
// as 1 and anything above 64 as 64) sets how many slots are in use; one slot
// always stays free, so capacity is ring size minus one. Each command is first
// accepted and latched, then executed against the head/tail registers and the
// ring store, whose read of the head entry is registered. A finished
// result waits in an output register, and the next command is accepted while
// it waits; execution of that command holds until the result register drains.
// No word is accepted while reset is held.
module circular_char_fifo
    import cfifo_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [2:0] cmd, [10:3] data_in
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // [7:0] data_out, [8] is_empty,
                                                // [9] is_full, [12:10] err_code
    input  logic                 i_cfg_we,
    input  logic [SIZE_W-1:0]    i_cfg_wdata
);

    t_dp_ctrl ctrl;

    cfifo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_ctrl     (ctrl)
    );

    cfifo_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_s_tdata   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

### rtl/cfifo_checker.sv
module cfifo_checker
    import cfifo_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic [ERR_W-1:0] err;
    logic             empty;
    logic             full;

    assign err   = m_axis_tdata[BYTE_W+2 +: ERR_W];
    assign empty = m_axis_tdata[BYTE_W];
    assign full  = m_axis_tdata[BYTE_W+1];

    // Result word stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result word dropped before handshake");

    // A failed enqueue means the queue is full
    a_enq_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && err == ERR_ENQUEUE_FULL) |-> full)
        else $error("enqueue error without full flag");

    // A failed read-side command means the queue is empty
    a_rd_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (err == ERR_PEEK_EMPTY || err == ERR_REMOVE_EMPTY ||
                           err == ERR_DEQUEUE_EMPTY)) |-> empty)
        else $error("empty error without empty flag");

    // Any error returns a zero byte
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && err != ERR_OK) |-> (m_axis_tdata[BYTE_W-1:0] == '0))
        else $error("data byte nonzero on error");

    // One command in flight: accept stalls the input until the command has executed
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second command accepted before execute");

endmodule

bind circular_char_fifo cfifo_checker u_cfifo_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### test/tb_circular_char_fifo.sv
module tb_circular_char_fifo
    import cfifo_pkg::*;
();

    localparam int CYCLE_LIMIT  = 600000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;
    localparam int PAD_W        = S_TDATA_W - CMD_W - BYTE_W;

    // Command codes the block does not define; they must leave the queue alone
    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] din;
    } t_word;

    typedef struct packed {
        logic [BYTE_W-1:0] dout;
        logic              is_empty;
        logic              is_full;
        t_err              err;
    } t_reply;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 i_cfg_we      = 1'b0;
    logic [SIZE_W-1:0]    i_cfg_wdata   = '0;

    circular_char_fifo dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    t_word  pending_words[$];
    t_reply expected_replies[$];

    // Shadow of the ring: store, indices and size register
    logic [BYTE_W-1:0] ring_mem [MAX_DEPTH];
    int                head_pos      = 0;
    int                tail_pos      = 0;
    logic [SIZE_W-1:0] ring_size_reg = RING_SIZE_RST;

    int  cycle_cnt    = 0;
    int  mismatch_cnt = 0;
    int  accept_cnt   = 0;
    int  sent_cnt     = 0;
    int  tx_gap       = 0;
    int  rx_gap       = 0;
    int  rx_hold_left = 0;
    bit  rx_hold_req  = 1'b0;
    bit  rx_hold_seen = 1'b0;
    bit  rx_hold      = 1'b0;
    bit  tx_burst     = 1'b0;
    bit  rx_burst     = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Clamp the size register to the usable range
    function automatic int slots_in_use();
        if (ring_size_reg == 0)
            return 1;
        if (ring_size_reg > MAX_DEPTH)
            return MAX_DEPTH;
        return int'(ring_size_reg);
    endfunction

    function automatic int next_pos(input int idx);
        return (idx + 1 >= slots_in_use()) ? 0 : idx + 1;
    endfunction

    // Apply one command to the shadow ring and form the result word
    function automatic t_reply ring_predict(input t_word w);
        t_reply r;
        r     = '0;
        r.err = ERR_OK;
        case (w.cmd)
            CMD_ENQUEUE: begin
                if (next_pos(tail_pos) == head_pos) begin
                    r.err = ERR_ENQUEUE_FULL;
                end else begin
                    ring_mem[tail_pos] = w.din;
                    tail_pos = next_pos(tail_pos);
                end
            end
            CMD_PEEK: begin
                if (head_pos == tail_pos)
                    r.err = ERR_PEEK_EMPTY;
                else
                    r.dout = ring_mem[head_pos];
            end
            CMD_REMOVE: begin
                if (head_pos == tail_pos)
                    r.err = ERR_REMOVE_EMPTY;
                else
                    head_pos = next_pos(head_pos);
            end
            CMD_DEQUEUE: begin
                if (head_pos == tail_pos) begin
                    r.err = ERR_DEQUEUE_EMPTY;
                end else begin
                    r.dout   = ring_mem[head_pos];
                    head_pos = next_pos(head_pos);
                end
            end
            CMD_CLEAR: begin
                head_pos = 0;
                tail_pos = 0;
            end
            default: ;
        endcase
        r.is_empty = (head_pos == tail_pos);
        r.is_full  = (next_pos(tail_pos) == head_pos);
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic add_word(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] d);
        t_word w;
        w.cmd = c;
        w.din = d;
        pending_words.push_back(w);
    endtask

    // Wait until every word is sent and every result is back, then settle
    task automatic wait_drained();
        while (pending_words.size() != 0 || s_axis_tvalid || expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ring_size(input logic [SIZE_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Runs of fill-heavy, balanced and drain-heavy commands with random bytes
    task automatic random_words(input int count);
        int k;
        int enq_pct;
        int r;
        enq_pct = 50;
        for (k = 0; k < count; k++) begin
            if (k % 20 == 0) begin
                case ($urandom_range(0, 2))
                    0: enq_pct = 85;
                    1: enq_pct = 50;
                    default: enq_pct = 15;
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < enq_pct) begin
                add_word(CMD_ENQUEUE, rand_byte());
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    add_word(CMD_DEQUEUE, rand_byte());
                else if (r < 70)
                    add_word(CMD_PEEK, rand_byte());
                else if (r < 92)
                    add_word(CMD_REMOVE, rand_byte());
                else if (r < 96)
                    add_word(CMD_CLEAR, rand_byte());
                else
                    add_word(CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
                             rand_byte());
            end
        end
    endtask

    // Sender: hold the word until taken, then advance or idle
    always @(negedge i_clk) begin
        t_word nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || accept_cnt == sent_cnt) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                nxt = pending_words.pop_front();
                s_axis_tdata  <= {{PAD_W{1'b0}}, nxt.din, nxt.cmd};
                s_axis_tvalid <= 1'b1;
                sent_cnt++;
                if (!tx_burst && $urandom_range(0, 2) == 0)
                    tx_gap = pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold: count it down once started by a request
    always @(negedge i_clk) begin
        if (rx_hold_req != rx_hold_seen) begin
            rx_hold_seen = rx_hold_req;
            rx_hold_left = LONG_HOLD;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            rx_hold <= 1'b1;
        end else begin
            rx_hold <= 1'b0;
        end
    end

    // Receiver: random stalls, plus the long hold
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!rx_burst && $urandom_range(0, 2) == 0)
                    rx_gap = pick_gap();
            end
        end
    end

    // Predict on every accepted command word, check every accepted result word
    always @(posedge i_clk) begin
        t_word  w_in;
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            head_pos      = 0;
            tail_pos      = 0;
            ring_size_reg = RING_SIZE_RST;
        end else begin
            if (i_cfg_we)
                ring_size_reg = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                w_in.cmd = s_axis_tdata[CMD_W-1:0];
                w_in.din = s_axis_tdata[CMD_W +: BYTE_W];
                expected_replies.push_back(ring_predict(w_in));
                accept_cnt++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.dout     = m_axis_tdata[7:0];
                got.is_empty = m_axis_tdata[8];
                got.is_full  = m_axis_tdata[9];
                got.err      = t_err'(m_axis_tdata[12:10]);
                if (expected_replies.size() == 0) begin
                    if (mismatch_cnt < REPORT_MAX)
                        $display("unexpected result word %h", m_axis_tdata);
                    mismatch_cnt++;
                end else begin
                    want = expected_replies.pop_front();
                    if (got != want) begin
                        if (mismatch_cnt < REPORT_MAX)
                            $display("mismatch: expected %02h/%b/%b/%0d got %02h/%b/%b/%0d",
                                     want.dout, want.is_empty, want.is_full, want.err,
                                     got.dout, got.is_empty, got.is_full, got.err);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int k;
        int ph;
        logic [SIZE_W-1:0] sizes [12];
        sizes = '{7'd64, 7'd5, 7'd2, 7'd1, 7'd0, 7'd127, 7'd9, 7'd33, 7'd3, 7'd64,
                  7'd17, 7'd63};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty queue at reset size: every read fails, unused codes do nothing
        add_word(CMD_PEEK, 8'hff);
        add_word(CMD_REMOVE, 8'h00);
        add_word(CMD_DEQUEUE, 8'hff);
        add_word(CMD_UNUSED_FIRST, 8'h00);
        add_word(CMD_UNUSED_LAST, 8'hff);
        add_word(CMD_CLEAR, 8'h00);
        // Fill to capacity, overflow once, drain, then write the last slot too
        add_word(CMD_ENQUEUE, 8'h00);
        add_word(CMD_ENQUEUE, 8'hff);
        add_word(CMD_PEEK, 8'h00);
        for (k = 0; k < MAX_DEPTH - 3; k++)
            add_word(CMD_ENQUEUE, rand_byte());
        add_word(CMD_ENQUEUE, 8'h5a);
        add_word(CMD_PEEK, 8'h00);
        for (k = 0; k < MAX_DEPTH - 1; k++)
            add_word(CMD_DEQUEUE, rand_byte());
        add_word(CMD_ENQUEUE, rand_byte());
        add_word(CMD_DEQUEUE, 8'h00);
        add_word(CMD_CLEAR, 8'hff);
        wait_drained();

        // Single slot: always both empty and full
        write_ring_size(SIZE_W'(1));
        add_word(CMD_ENQUEUE, 8'ha5);
        add_word(CMD_PEEK, 8'h00);
        add_word(CMD_REMOVE, 8'h00);
        add_word(CMD_DEQUEUE, 8'h00);
        add_word(CMD_CLEAR, 8'h00);
        add_word(CMD_UNUSED_FIRST, 8'h3c);
        wait_drained();

        // Two slots: capacity of one
        write_ring_size(SIZE_W'(2));
        add_word(CMD_ENQUEUE, 8'h81);
        add_word(CMD_ENQUEUE, 8'h7e);
        add_word(CMD_PEEK, 8'h00);
        add_word(CMD_DEQUEUE, 8'h00);
        add_word(CMD_DEQUEUE, 8'h00);
        wait_drained();

        // Shrink the ring while it holds data; indices keep their values
        write_ring_size(SIZE_W'(8));
        for (k = 0; k < 5; k++)
            add_word(CMD_ENQUEUE, rand_byte());
        wait_drained();
        write_ring_size(SIZE_W'(3));
        add_word(CMD_DEQUEUE, 8'h00);
        add_word(CMD_PEEK, 8'h00);
        add_word(CMD_ENQUEUE, 8'hc3);
        add_word(CMD_ENQUEUE, 8'h3c);
        for (k = 0; k < 4; k++)
            add_word(CMD_DEQUEUE, 8'h00);
        wait_drained();

        // Random phases across sizes, out-of-range settings included
        for (ph = 0; ph < 12; ph++) begin
            write_ring_size(sizes[ph]);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            random_words(80);
            if (ph == 2 || ph == 9)
                rx_hold_req = ~rx_hold_req;
            wait_drained();
        end

        if (mismatch_cnt == 0 && expected_replies.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
